// ===== design/dsb_pkg.sv =====
// ----------------------------------------------------------------------------
// dsb_pkg
// shared types, codes and helpers for the damped spring camera bob
// ----------------------------------------------------------------------------
`default_nettype none

package dsb_pkg;

    localparam int unsigned NUM_AXES  = 3;
    localparam int unsigned ANGLE_W   = 32;
    localparam int unsigned COEF_W    = 24;
    localparam int unsigned LIMIT_W   = 18;
    localparam int unsigned DT_W      = 16;
    localparam int unsigned Q_SHIFT   = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 24;

    // products and intermediate widths of the spring step
    localparam int unsigned MUL_W   = COEF_W + 1 + ANGLE_W;       // k*angle, r*vel
    localparam int unsigned SUM_W   = MUL_W + 1;                  // their sum
    localparam int unsigned FORCE_W = SUM_W - Q_SHIFT;            // force in q26.16
    localparam int unsigned DTF_W   = DT_W + 1 + FORCE_W;         // dt*force
    localparam int unsigned DTV_W   = DT_W + 1 + ANGLE_W;         // dt*vel

    localparam logic [COEF_W-1:0]  STIFF_RST = 24'd6553600;
    localparam logic [COEF_W-1:0]  DAMP_RST  = 24'd58982;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 18'd34315;

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_IMPULSE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_SLIDING = 2'd2,
        MODE_UNUSED  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE  = 2'd0,
        CFG_STIFF = 2'd1,
        CFG_DAMP  = 2'd2,
        CFG_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IMP,
        ST_MUL,
        ST_FORCE,
        ST_DTF,
        ST_VEL,
        ST_DTV,
        ST_ANG,
        ST_PUSH
    } t_state;

    // strobes from the sequencer to every lane
    typedef struct packed {
        logic clear;
        logic imp_en;
        logic mul_en;
        logic force_en;
        logic dtf_en;
        logic vel_en;
        logic dtv_en;
        logic ang_en;
    } t_lane_ctrl;

    // saturate a sign-extended value to 32 bits
    function automatic logic signed [ANGLE_W-1:0] sat_q32(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (x > hi) begin
            return hi[ANGLE_W-1:0];
        end else if (x < lo) begin
            return lo[ANGLE_W-1:0];
        end
        return x[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/dsb_channels.sv =====
// ----------------------------------------------------------------------------
// dsb channels
// valid/ready channels for input items, result items and register writes
// ----------------------------------------------------------------------------
`default_nettype none

interface dsb_in_if
    import dsb_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic [DT_W-1:0]           time_step;
    logic signed [ANGLE_W-1:0] pitch_impulse;
    logic signed [ANGLE_W-1:0] yaw_impulse;
    logic signed [ANGLE_W-1:0] roll_impulse;

    modport source (output valid, opcode, time_step, pitch_impulse, yaw_impulse,
                    roll_impulse, input ready);
    modport sink   (input valid, opcode, time_step, pitch_impulse, yaw_impulse,
                    roll_impulse, output ready);
endinterface

interface dsb_out_if
    import dsb_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ANGLE_W-1:0] roll_angle;

    modport source (output valid, pitch_angle, yaw_angle, roll_angle, input ready);
    modport sink   (input valid, pitch_angle, yaw_angle, roll_angle, output ready);
endinterface

interface dsb_cfg_if
    import dsb_pkg::*;
    ;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/damped_spring_camera_bob_unit.sv =====
// sequence: a running tick steps the lanes through mul, force, dtf, vel, dtv and ang,
//   an impulse through imp, a tick in any other mode straight to push; push waits
//   while the result register is full; one item at a time, so a running tick is the
//   longest, set by the six-step chain of the spring lanes
// reset: synchronous active-low; velocities and angles clear to zero, registers take
//   their defaults, no result pending
// ----------------------------------------------------------------------------
// damped_spring_camera_bob_unit
// three-axis damped spring for camera bob, one lane per axis, q16.16 state
// ----------------------------------------------------------------------------
`default_nettype none

module damped_spring_camera_bob_unit
    import dsb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dsb_in_if.sink    i_item,
    dsb_out_if.source o_result,
    dsb_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [1:0]         r_mode;
    logic [COEF_W-1:0]  r_stiff;
    logic [COEF_W-1:0]  r_damp;
    logic [LIMIT_W-1:0] r_limit;

    // item held for the lanes while the sequencer runs
    logic [DT_W-1:0]           r_dt;
    logic signed [ANGLE_W-1:0] r_imp [NUM_AXES];

    logic                      in_fire;
    logic                      cfg_fire;
    logic                      mode_clear;
    logic                      push;
    logic                      slot_free;
    logic                      seq_ready;
    t_lane_ctrl                lane_ctrl;
    logic signed [ANGLE_W-1:0] lane_angle [NUM_AXES];

    assign in_fire  = i_item.valid && seq_ready;
    assign cfg_fire = i_cfg.valid && i_cfg.ready;

    // register writes are always taken
    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = seq_ready;

    // a mode write that changes the mode wipes every axis
    assign mode_clear = cfg_fire && (i_cfg.index == CFG_MODE)
                        && (i_cfg.data[1:0] != r_mode);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NONE;
            r_stiff <= STIFF_RST;
            r_damp  <= DAMP_RST;
            r_limit <= LIMIT_RST;
        end else if (cfg_fire) begin
            case (i_cfg.index)
                CFG_MODE:  r_mode  <= i_cfg.data[1:0];
                CFG_STIFF: r_stiff <= i_cfg.data[COEF_W-1:0];
                CFG_DAMP:  r_damp  <= i_cfg.data[COEF_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg.data[LIMIT_W-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    // latch the accepted item
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_dt     <= i_item.time_step;
            r_imp[0] <= i_item.pitch_impulse;
            r_imp[1] <= i_item.yaw_impulse;
            r_imp[2] <= i_item.roll_impulse;
        end
    end

    // the opcode is decided from the live item, the lanes work from the latch
    dsb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (in_fire),
        .i_op        (i_item.opcode),
        .i_running   (r_mode == MODE_RUNNING),
        .i_clear     (mode_clear),
        .i_slot_free (slot_free),
        .o_ready     (seq_ready),
        .o_push      (push),
        .o_ctrl      (lane_ctrl)
    );

    // one lane per axis: pitch, yaw, roll
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        dsb_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (lane_ctrl),
            .i_stiff   (r_stiff),
            .i_damp    (r_damp),
            .i_limit   (r_limit),
            .i_dt      (r_dt),
            .i_impulse (r_imp[g]),
            .o_angle   (lane_angle[g])
        );
    end

    // result register frees the sequencer while a result waits downstream
    dsb_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (push),
        .i_angle     (lane_angle),
        .o_slot_free (slot_free),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== design/dsb_lane.sv =====
// ----------------------------------------------------------------------------
// dsb_lane
// one axis: velocity and angle state with a staged spring step
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_lane
    import dsb_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_lane_ctrl                i_ctrl,
    input  wire logic [COEF_W-1:0]         i_stiff,
    input  wire logic [COEF_W-1:0]         i_damp,
    input  wire logic [LIMIT_W-1:0]        i_limit,
    input  wire logic [DT_W-1:0]           i_dt,
    input  wire logic signed [ANGLE_W-1:0] i_impulse,
    output logic signed [ANGLE_W-1:0]      o_angle
);

    logic signed [ANGLE_W-1:0] r_vel, n_vel;
    logic signed [ANGLE_W-1:0] r_ang, n_ang;
    logic signed [MUL_W-1:0]   r_pk;
    logic signed [MUL_W-1:0]   r_pr;
    logic signed [FORCE_W-1:0] r_force;
    logic signed [DTF_W-1:0]   r_dtf;
    logic signed [DTV_W-1:0]   r_dtv;

    logic signed [SUM_W-1:0]   neg_sum;
    logic signed [DT_W:0]      dt_s;
    logic signed [ANGLE_W:0]   lim_s;
    logic signed [ANGLE_W:0]   imp_sum;
    logic signed [DTF_W-Q_SHIFT:0] vel_sum;
    logic signed [DTV_W-Q_SHIFT:0] ang_sum;
    logic signed [ANGLE_W-1:0] nv_sat;
    logic                      outward;

    assign dt_s  = $signed({1'b0, i_dt});
    assign lim_s = $signed({{(ANGLE_W + 1 - LIMIT_W){1'b0}}, i_limit});

    always_comb begin
        neg_sum = -(SUM_W'(r_pk) + SUM_W'(r_pr));
        imp_sum = (ANGLE_W + 1)'(r_vel) + (ANGLE_W + 1)'(i_impulse);
        vel_sum = (DTF_W - Q_SHIFT + 1)'(r_vel)
                + (DTF_W - Q_SHIFT + 1)'($signed(r_dtf[DTF_W-1:Q_SHIFT]));
        nv_sat  = sat_q32(64'(vel_sum));
        // beyond the stray limit and still heading outward
        outward = ((ANGLE_W + 1)'(r_ang) > lim_s && nv_sat > 0)
               || ((ANGLE_W + 1)'(r_ang) < -lim_s && nv_sat < 0);
        ang_sum = (DTV_W - Q_SHIFT + 1)'(r_ang)
                + (DTV_W - Q_SHIFT + 1)'($signed(r_dtv[DTV_W-1:Q_SHIFT]));

        n_vel = r_vel;
        n_ang = r_ang;
        if (i_ctrl.clear) begin
            n_vel = '0;
            n_ang = '0;
        end else if (i_ctrl.imp_en) begin
            n_vel = sat_q32(64'(imp_sum));
        end else if (i_ctrl.vel_en) begin
            n_vel = outward ? (nv_sat >>> 1) : nv_sat;
        end else if (i_ctrl.ang_en) begin
            n_ang = sat_q32(64'(ang_sum));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel <= '0;
            r_ang <= '0;
        end else begin
            r_vel <= n_vel;
            r_ang <= n_ang;
        end
    end

    // datapath registers: mul forms k*angle and r*vel, force negates and shifts, dtf and dtv multiply by dt
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_pk <= $signed({1'b0, i_stiff}) * r_ang;
            r_pr <= $signed({1'b0, i_damp}) * r_vel;
        end
        if (i_ctrl.force_en) begin
            r_force <= $signed(neg_sum[SUM_W-1:Q_SHIFT]);
        end
        if (i_ctrl.dtf_en) begin
            r_dtf <= dt_s * r_force;
        end
        if (i_ctrl.dtv_en) begin
            r_dtv <= dt_s * r_vel;
        end
    end

    assign o_angle = r_ang;

endmodule

`default_nettype wire

// ===== design/dsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsb_ctrl
// sequencer that steps all lanes through one item at a time
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_ctrl
    import dsb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire logic  i_op,
    input  wire logic  i_running,
    input  wire logic  i_clear,
    input  wire logic  i_slot_free,
    output logic       o_ready,
    output logic       o_push,
    output t_lane_ctrl o_ctrl
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_push  = 1'b0;
        o_ctrl  = '0;
        o_ctrl.clear = i_clear;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_fire) begin
                    if (i_op == OP_IMPULSE) begin
                        n_state = ST_IMP;
                    end else if (i_running) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_PUSH;
                    end
                end
            end
            ST_IMP: begin
                o_ctrl.imp_en = 1'b1;
                n_state = ST_PUSH;
            end
            ST_MUL: begin
                o_ctrl.mul_en = 1'b1;
                n_state = ST_FORCE;
            end
            ST_FORCE: begin
                o_ctrl.force_en = 1'b1;
                n_state = ST_DTF;
            end
            ST_DTF: begin
                o_ctrl.dtf_en = 1'b1;
                n_state = ST_VEL;
            end
            ST_VEL: begin
                o_ctrl.vel_en = 1'b1;
                n_state = ST_DTV;
            end
            ST_DTV: begin
                o_ctrl.dtv_en = 1'b1;
                n_state = ST_ANG;
            end
            ST_ANG: begin
                o_ctrl.ang_en = 1'b1;
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_slot_free) begin
                    o_push  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/dsb_merge.sv =====
// ----------------------------------------------------------------------------
// dsb_merge
// gathers the three lane angles into one registered result item
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_merge
    import dsb_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire logic signed [ANGLE_W-1:0] i_angle [NUM_AXES],
    output logic                           o_slot_free,
    dsb_out_if.source                      o_result
);

    logic                      r_valid;
    logic signed [ANGLE_W-1:0] r_pitch, r_yaw, r_roll;

    assign o_slot_free = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pitch <= i_angle[0];
            r_yaw   <= i_angle[1];
            r_roll  <= i_angle[2];
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.pitch_angle = r_pitch;
    assign o_result.yaw_angle   = r_yaw;
    assign o_result.roll_angle  = r_roll;

endmodule

`default_nettype wire

// ===== design/dsb_checker.sv =====
// ----------------------------------------------------------------------------
// dsb_port_checker
// port-level checks for the damped spring camera bob
// ----------------------------------------------------------------------------
`default_nettype none

module dsb_port_checker
    import dsb_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_in_valid,
    input wire logic                      i_in_ready,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic signed [ANGLE_W-1:0] i_pitch,
    input wire logic                      i_cfg_ready
);

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_pitch))
        else $error("stalled result changed");

    // one item at a time: busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while previous one still in flight");

    // a new result only comes out of a busy sequencer
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without an item being worked on");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register write port stalled");

endmodule

bind damped_spring_camera_bob_unit dsb_port_checker u_dsb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_pitch     (o_result.pitch_angle),
    .i_cfg_ready (i_cfg.ready)
);

`default_nettype wire
